/* rtl/assert_macros.svh */
// shared assertion macros for the deframer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising edge, held off during reset
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// implication checked in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// plain invariant
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error(msg);

`endif

/* rtl/spd_pkg.sv */
package spd_pkg;

  // parser phase, one-hot
  typedef enum logic [7:0] {
    PH_HUNT    = 8'b0000_0001,
    PH_PRODUCT = 8'b0000_0010,
    PH_ID      = 8'b0000_0100,
    PH_LEN_LO  = 8'b0000_1000,
    PH_LEN_HI  = 8'b0001_0000,
    PH_HEAD    = 8'b0010_0000,
    PH_DATA    = 8'b0100_0000,
    PH_CSUM    = 8'b1000_0000
  } phase_e;

  // byte role codes
  localparam logic [3:0] ROLE_DISCARD = 4'd0;
  localparam logic [3:0] ROLE_START   = 4'd1;
  localparam logic [3:0] ROLE_PRODUCT = 4'd2;
  localparam logic [3:0] ROLE_ID      = 4'd3;
  localparam logic [3:0] ROLE_LEN_LO  = 4'd4;
  localparam logic [3:0] ROLE_LEN_HI  = 4'd5;
  localparam logic [3:0] ROLE_HEAD    = 4'd6;
  localparam logic [3:0] ROLE_DATA    = 4'd7;
  localparam logic [3:0] ROLE_CSUM    = 4'd8;

  // status codes
  localparam logic [1:0] ST_NONE     = 2'd0;
  localparam logic [1:0] ST_START    = 2'd1;
  localparam logic [1:0] ST_COMPLETE = 2'd2;

  // configuration register indexes and reset values
  localparam logic [7:0] CFG_START_BYTE   = 8'd0;
  localparam logic [7:0] CFG_PRODUCT_BYTE = 8'd1;
  localparam logic [7:0] StartByteRst     = 8'd90;
  localparam logic [7:0] ProductByteRst   = 8'd119;

  // one result transaction
  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  byte_role;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic [7:0]  packet_id;
    logic [15:0] payload_length;
  } result_t;

endpackage

/* rtl/spd_parser.sv */
`include "assert_macros.svh"

module spd_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       rx_byte_i,
  input  logic [7:0]       start_byte_i,
  input  logic [7:0]       product_byte_i,
  output spd_pkg::result_t res_o
);

  spd_pkg::phase_e phase_q, phase_d;
  logic [16:0] count_q, count_d;
  logic [15:0] len_q, len_d;
  logic [7:0]  xor_q, xor_d;
  logic [7:0]  id_q, id_d;

  logic        start_hit;
  logic [15:0] len_hi_new;
  logic [17:0] count_inc_wide;
  logic [16:0] count_inc;
  logic        overrun;

  assign start_hit      = (rx_byte_i == start_byte_i);
  assign len_hi_new     = {rx_byte_i, len_q[7:0]};
  assign count_inc_wide = {1'b0, count_q} + 18'd1;
  assign count_inc      = count_inc_wide[16:0];
  assign overrun        = (count_inc_wide > {2'b00, len_q});

  // next state and result for the byte at the head of the pipe
  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    len_d   = len_q;
    xor_d   = xor_q;
    id_d    = id_q;
    res_o.status        = spd_pkg::ST_NONE;
    res_o.byte_role     = spd_pkg::ROLE_DISCARD;
    res_o.payload_byte  = 8'd0;
    res_o.payload_index = 16'd0;
    unique case (phase_q)
      spd_pkg::PH_PRODUCT: begin
        if (rx_byte_i == product_byte_i) begin
          phase_d         = spd_pkg::PH_ID;
          res_o.byte_role = spd_pkg::ROLE_PRODUCT;
        end else begin
          // resync: look at this byte as a start
          count_d = 17'd0;
          if (start_hit) begin
            phase_d         = spd_pkg::PH_PRODUCT;
            res_o.status    = spd_pkg::ST_START;
            res_o.byte_role = spd_pkg::ROLE_START;
          end else begin
            phase_d = spd_pkg::PH_HUNT;
          end
        end
      end
      spd_pkg::PH_ID: begin
        id_d            = rx_byte_i;
        phase_d         = spd_pkg::PH_LEN_LO;
        res_o.byte_role = spd_pkg::ROLE_ID;
      end
      spd_pkg::PH_LEN_LO: begin
        len_d           = {len_q[15:8], rx_byte_i};
        xor_d           = rx_byte_i;
        phase_d         = spd_pkg::PH_LEN_HI;
        res_o.byte_role = spd_pkg::ROLE_LEN_LO;
      end
      spd_pkg::PH_LEN_HI: begin
        len_d           = len_hi_new;
        xor_d           = xor_q ^ rx_byte_i;
        count_d         = 17'd0;
        phase_d         = (len_hi_new == 16'd0) ? spd_pkg::PH_CSUM : spd_pkg::PH_HEAD;
        res_o.byte_role = spd_pkg::ROLE_LEN_HI;
      end
      spd_pkg::PH_HEAD: begin
        xor_d              = xor_q ^ rx_byte_i;
        res_o.byte_role    = spd_pkg::ROLE_HEAD;
        res_o.payload_byte = rx_byte_i;
        if (len_q <= 16'd1) begin
          phase_d = spd_pkg::PH_CSUM;
          count_d = 17'd0;
        end else begin
          phase_d = spd_pkg::PH_DATA;
          count_d = 17'd1;
        end
      end
      spd_pkg::PH_DATA: begin
        if (overrun) begin
          // guard against running past the declared length
          count_d = 17'd0;
          if (start_hit) begin
            phase_d         = spd_pkg::PH_PRODUCT;
            res_o.status    = spd_pkg::ST_START;
            res_o.byte_role = spd_pkg::ROLE_START;
          end else begin
            phase_d = spd_pkg::PH_HUNT;
          end
        end else begin
          xor_d               = xor_q ^ rx_byte_i;
          res_o.byte_role     = spd_pkg::ROLE_DATA;
          res_o.payload_byte  = rx_byte_i;
          res_o.payload_index = count_q[15:0];
          if (count_inc == {1'b0, len_q}) begin
            phase_d = spd_pkg::PH_CSUM;
            count_d = 17'd0;
          end else begin
            count_d = count_inc;
          end
        end
      end
      spd_pkg::PH_CSUM: begin
        res_o.byte_role = spd_pkg::ROLE_CSUM;
        if (xor_q == rx_byte_i) begin
          res_o.status = spd_pkg::ST_COMPLETE;
        end
        phase_d = spd_pkg::PH_HUNT;
        count_d = 17'd0;
      end
      spd_pkg::PH_HUNT: begin
        count_d = 17'd0;
        if (start_hit) begin
          phase_d         = spd_pkg::PH_PRODUCT;
          res_o.status    = spd_pkg::ST_START;
          res_o.byte_role = spd_pkg::ROLE_START;
        end else begin
          phase_d = spd_pkg::PH_HUNT;
        end
      end
      default: begin
        phase_d = spd_pkg::PH_HUNT;
        count_d = 17'd0;
      end
    endcase
    res_o.packet_id      = id_d;
    res_o.payload_length = len_d;
  end

  // parser state, updated once per transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= spd_pkg::PH_HUNT;
      count_q <= 17'd0;
      len_q   <= 16'd0;
      xor_q   <= 8'd0;
      id_q    <= 8'd0;
    end else if (step_i) begin
      phase_q <= phase_d;
      count_q <= count_d;
      len_q   <= len_d;
      xor_q   <= xor_d;
      id_q    <= id_d;
    end
  end

  `ASSERT_NEXT(a_csum_then_hunt, step_i && (phase_q == spd_pkg::PH_CSUM), phase_q == spd_pkg::PH_HUNT, "checksum byte not followed by hunting")
  `ASSERT_ALWAYS(a_count_in_range, count_q <= {1'b0, len_q}, "payload count beyond declared length")
  `ASSERT_IMPL(a_complete_is_csum, res_o.status == spd_pkg::ST_COMPLETE, (res_o.byte_role == spd_pkg::ROLE_CSUM) && (phase_q == spd_pkg::PH_CSUM), "completion outside checksum byte")

endmodule

/* rtl/sensor_packet_deframer_top.sv */
// Byte stream deframer: one received byte per input transaction, one result
// transaction per byte giving its role, payload byte and index, packet id and
// declared length. A byte is accepted every cycle while the result side keeps
// up; each byte passes an input register, then single-pass parser logic into the
// result register. The parser state update loops through the parser's own
// registers. Configuration writes are always ready and take effect on the next
// byte; write them only while idle.
`include "assert_macros.svh"

module sensor_packet_deframer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  // byte input
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [3:0]  byte_role_o,
  output logic [7:0]  payload_byte_o,
  output logic [15:0] payload_index_o,
  output logic [7:0]  packet_id_o,
  output logic [15:0] payload_length_o
);

  logic [7:0]       start_byte_q;
  logic [7:0]       product_byte_q;
  logic             in_valid_q;
  logic [7:0]       in_byte_q;
  logic             out_valid_q;
  spd_pkg::result_t out_res_q;
  spd_pkg::result_t res;
  logic             advance;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q   <= spd_pkg::StartByteRst;
      product_byte_q <= spd_pkg::ProductByteRst;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == spd_pkg::CFG_START_BYTE) begin
        start_byte_q <= cfg_data_i;
      end
      if (cfg_index_i == spd_pkg::CFG_PRODUCT_BYTE) begin
        product_byte_q <= cfg_data_i;
      end
    end
  end

  // pipe handshake: parser step moves a byte into the result register
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= rx_byte_i;
    end
  end

  spd_parser u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (advance),
    .rx_byte_i      (in_byte_q),
    .start_byte_i   (start_byte_q),
    .product_byte_i (product_byte_q),
    .res_o          (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_res_q.status;
  assign byte_role_o      = out_res_q.byte_role;
  assign payload_byte_o   = out_res_q.payload_byte;
  assign payload_index_o  = out_res_q.payload_index;
  assign packet_id_o      = out_res_q.packet_id;
  assign payload_length_o = out_res_q.payload_length;

  `ASSERT_NEXT(a_held_byte_kept, in_valid_q && !advance, in_valid_q && $stable(in_byte_q), "stalled byte lost from input register")
  `ASSERT_NEXT(a_step_gives_result, advance, out_valid_q, "parser step without result")

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

  // register index outside the two defined registers, writes to it are dropped
  localparam logic [7:0] CFG_UNUSED = 8'd2;
  localparam int unsigned RANDOM_BYTES = 190;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam logic [15:0] LONG_LENGTH = 16'd300;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;

  logic        cfg_valid = 1'b0;
  logic [7:0]  cfg_index = 8'd0;
  logic [7:0]  cfg_data = 8'd0;
  logic        cfg_ready_o;

  logic        in_valid = 1'b0;
  logic [7:0]  rx_byte = 8'd0;
  logic        in_ready_o;

  logic        out_valid_o;
  logic        out_ready = 1'b0;
  logic [1:0]  status_o;
  logic [3:0]  byte_role_o;
  logic [7:0]  payload_byte_o;
  logic [15:0] payload_index_o;
  logic [7:0]  packet_id_o;
  logic [15:0] payload_length_o;

  // bytes waiting to be sent and results waiting to come back
  logic [7:0]       tx_bytes[$];
  spd_pkg::result_t pending_results[$];

  int unsigned n_pushed = 0;
  int unsigned n_accepted = 0;
  int unsigned n_results = 0;
  int unsigned n_good_packets = 0;
  int unsigned n_settings = 0;
  int unsigned n_errors = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  // deframer state as predicted by the testbench
  spd_pkg::phase_e ph = spd_pkg::PH_HUNT;
  logic [16:0] pay_cnt = '0;
  logic [15:0] decl_len = '0;
  logic [7:0]  run_xor = '0;
  logic [7:0]  cur_id = '0;
  logic [7:0]  start_val = spd_pkg::StartByteRst;
  logic [7:0]  product_val = spd_pkg::ProductByteRst;

  sensor_packet_deframer_top i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready_o),
    .rx_byte_i        (rx_byte),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready),
    .status_o         (status_o),
    .byte_role_o      (byte_role_o),
    .payload_byte_o   (payload_byte_o),
    .payload_index_o  (payload_index_o),
    .packet_id_o      (packet_id_o),
    .payload_length_o (payload_length_o)
  );

  always #1 clk_i = ~clk_i;

  // byte seen as a possible packet opener
  function automatic void take_as_start(input logic [7:0] b, inout spd_pkg::result_t r);
    pay_cnt = '0;
    if (b == start_val) begin
      ph          = spd_pkg::PH_PRODUCT;
      r.status    = spd_pkg::ST_START;
      r.byte_role = spd_pkg::ROLE_START;
    end else begin
      ph          = spd_pkg::PH_HUNT;
      r.byte_role = spd_pkg::ROLE_DISCARD;
    end
  endfunction

  // next deframer result for one received byte
  function automatic spd_pkg::result_t deframe_byte(logic [7:0] b);
    spd_pkg::result_t r;
    r = '0;
    r.status = spd_pkg::ST_NONE;
    r.byte_role = spd_pkg::ROLE_DISCARD;
    case (ph)
      spd_pkg::PH_HUNT: begin
        take_as_start(b, r);
      end
      spd_pkg::PH_PRODUCT: begin
        if (b == product_val) begin
          ph = spd_pkg::PH_ID;
          r.byte_role = spd_pkg::ROLE_PRODUCT;
        end else begin
          take_as_start(b, r);
        end
      end
      spd_pkg::PH_ID: begin
        cur_id = b;
        ph = spd_pkg::PH_LEN_LO;
        r.byte_role = spd_pkg::ROLE_ID;
      end
      spd_pkg::PH_LEN_LO: begin
        decl_len[7:0] = b;
        run_xor = b;
        ph = spd_pkg::PH_LEN_HI;
        r.byte_role = spd_pkg::ROLE_LEN_LO;
      end
      spd_pkg::PH_LEN_HI: begin
        decl_len[15:8] = b;
        run_xor ^= b;
        pay_cnt = '0;
        ph = (decl_len == 16'd0) ? spd_pkg::PH_CSUM : spd_pkg::PH_HEAD;
        r.byte_role = spd_pkg::ROLE_LEN_HI;
      end
      spd_pkg::PH_HEAD: begin
        run_xor ^= b;
        r.byte_role = spd_pkg::ROLE_HEAD;
        r.payload_byte = b;
        if (decl_len <= 16'd1) begin
          ph = spd_pkg::PH_CSUM;
          pay_cnt = '0;
        end else begin
          ph = spd_pkg::PH_DATA;
          pay_cnt = 17'd1;
        end
      end
      spd_pkg::PH_DATA: begin
        // overrun guard, cannot trigger while the count is consistent
        if (pay_cnt + 17'd1 > {1'b0, decl_len}) begin
          take_as_start(b, r);
        end else begin
          run_xor ^= b;
          r.byte_role = spd_pkg::ROLE_DATA;
          r.payload_byte = b;
          r.payload_index = pay_cnt[15:0];
          pay_cnt = pay_cnt + 17'd1;
          if (pay_cnt == {1'b0, decl_len}) begin
            ph = spd_pkg::PH_CSUM;
            pay_cnt = '0;
          end
        end
      end
      spd_pkg::PH_CSUM: begin
        r.byte_role = spd_pkg::ROLE_CSUM;
        if (run_xor == b) r.status = spd_pkg::ST_COMPLETE;
        ph = spd_pkg::PH_HUNT;
        pay_cnt = '0;
      end
      default: begin
        ph = spd_pkg::PH_HUNT;
        pay_cnt = '0;
      end
    endcase
    r.packet_id = cur_id;
    r.payload_length = decl_len;
    return r;
  endfunction

  function automatic void push_byte(logic [7:0] b);
    tx_bytes.push_back(b);
    n_pushed++;
  endfunction

  // framed packet; a short one lacks its last payload byte and its checksum
  function automatic void queue_packet(logic [7:0] id, logic [15:0] len, bit good_sum,
                                       bit cut_short);
    logic [7:0] sum;
    logic [7:0] d;
    int unsigned n_data;
    sum = len[7:0] ^ len[15:8];
    n_data = cut_short ? int'(len) - 1 : int'(len);
    push_byte(start_val);
    push_byte(product_val);
    push_byte(id);
    push_byte(len[7:0]);
    push_byte(len[15:8]);
    for (int unsigned k = 0; k < n_data; k++) begin
      d = 8'($urandom);
      sum ^= d;
      push_byte(d);
    end
    if (!cut_short) push_byte(good_sum ? sum : sum ^ (8'd1 << $urandom_range(7)));
  endfunction

  // mostly well-formed packets, with noise and broken framing mixed in
  function automatic void queue_random_traffic(int unsigned n_bytes);
    int unsigned first;
    int unsigned pick;
    logic [7:0]  b;
    logic [15:0] len;
    first = n_pushed;
    while (n_pushed - first < n_bytes) begin
      pick = $urandom_range(99);
      len = ($urandom_range(4) == 0) ? 16'($urandom_range(40, 7)) : 16'($urandom_range(6));
      if (pick < 70) begin
        queue_packet(8'($urandom), len, $urandom_range(99) < 85, 1'b0);
      end else if (pick < 80) begin
        repeat ($urandom_range(4, 1)) push_byte(8'($urandom));
      end else if (pick < 90) begin
        b = 8'($urandom);
        if ($urandom_range(99) < 30) b = start_val;
        if (b == product_val) b = ~b;
        push_byte(start_val);
        push_byte(b);
      end else begin
        queue_packet(8'($urandom), len + 16'd1, 1'b1, 1'b1);
      end
    end
  endfunction

  task automatic write_reg(logic [7:0] idx, logic [7:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    case (idx)
      spd_pkg::CFG_START_BYTE:   start_val = val;
      spd_pkg::CFG_PRODUCT_BYTE: product_val = val;
      default:                   ;
    endcase
  endtask

  // every byte sent and every result back, then let the pipeline settle
  task automatic wait_drained();
    while (n_accepted != n_pushed || pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      n_errors++;
    end
  endtask

  // byte driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready_o) begin
        pending_results.push_back(deframe_byte(rx_byte));
        n_accepted++;
      end
      if (!in_valid || in_ready_o) begin
        if (tx_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          rx_byte  <= tx_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and checker
  always @(posedge clk_i) begin : result_mon
    spd_pkg::result_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        n_results++;
        if (pending_results.size() == 0) begin
          $display("%0t: result with none expected, role %0d status %0d", $time,
                   byte_role_o, status_o);
          n_errors++;
        end else begin
          want = pending_results.pop_front();
          check_field("status", 16'(want.status), 16'(status_o));
          check_field("byte_role", 16'(want.byte_role), 16'(byte_role_o));
          check_field("payload_byte", 16'(want.payload_byte), 16'(payload_byte_o));
          check_field("payload_index", want.payload_index, payload_index_o);
          check_field("packet_id", 16'(want.packet_id), 16'(packet_id_o));
          check_field("payload_length", want.payload_length, payload_length_o);
          if (want.status == spd_pkg::ST_COMPLETE) n_good_packets++;
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // stimulus and phase sequencing
  initial begin
    logic [7:0]  cfg_start[5];
    logic [7:0]  cfg_product[5];
    int unsigned idle_in[5];
    int unsigned stall_out[5];

    cfg_start   = '{8'h00, 8'hff, 8'h5a, 8'($urandom), spd_pkg::StartByteRst};
    cfg_product = '{8'hff, 8'h00, 8'h5a, 8'($urandom), spd_pkg::ProductByteRst};
    idle_in     = '{61, 0, 30, 0, 30};
    stall_out   = '{0, 61, 30, 0, 30};

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: noise, start in the product slot, zero length with id at maximum
    push_byte(8'h00);
    push_byte(8'hff);
    push_byte(spd_pkg::StartByteRst);
    push_byte(spd_pkg::StartByteRst);
    push_byte(spd_pkg::ProductByteRst);
    push_byte(8'hff);
    push_byte(8'h00);
    push_byte(8'h00);
    push_byte(8'h00);
    // wrong product byte that is no start either
    push_byte(spd_pkg::StartByteRst);
    push_byte(8'h00);
    // length one: head then checksum
    push_byte(spd_pkg::StartByteRst);
    push_byte(spd_pkg::ProductByteRst);
    push_byte(8'h00);
    push_byte(8'h01);
    push_byte(8'h00);
    push_byte(8'hff);
    push_byte(8'hfe);
    // two payload bytes with a bad checksum
    push_byte(spd_pkg::StartByteRst);
    push_byte(spd_pkg::ProductByteRst);
    push_byte(8'h12);
    push_byte(8'h02);
    push_byte(8'h00);
    push_byte(8'hab);
    push_byte(8'hcd);
    push_byte(8'h65);
    wait_drained();
    n_settings++;

    // one long packet with a non-zero length high byte, back to back
    queue_packet(8'($urandom), LONG_LENGTH, 1'b1, 1'b0);
    wait_drained();

    for (int p = 0; p < 5; p++) begin
      send_idle_pct  = idle_in[p];
      recv_stall_pct = stall_out[p];
      write_reg(spd_pkg::CFG_START_BYTE, cfg_start[p]);
      write_reg(spd_pkg::CFG_PRODUCT_BYTE, cfg_product[p]);
      if (p == 2) write_reg(CFG_UNUSED, 8'h33);
      n_settings++;
      queue_random_traffic(RANDOM_BYTES);
      wait_drained();
    end

    if (pending_results.size() != 0) n_errors++;
    $display("covered %0d bytes over %0d register settings and four handshake patterns",
             n_accepted, n_settings);
    $display("checked %0d results, %0d packets with a matching checksum, %0d mismatches",
             n_results, n_good_packets, n_errors);
    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
